[src/oq_pkg.sv]
// Shared types and constants for the ordered queue.
`timescale 1ns / 1ps
package oq_pkg;

  localparam int CAPACITY = 16;
  localparam int KeyW     = 31;
  localparam int DurW     = 31;
  localparam int CountW   = 5;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_POP    = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_REMOVE = 2'd3
  } kind_e;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic            append;
    logic            del;
    logic [KeyW-1:0] key;
    logic [DurW-1:0] dur;
  } oq_cmd_t;

endpackage

[src/oq_cell.sv]
// One storage cell of the queue row: compare, priority chain and shift toward the head.
`timescale 1ns / 1ps
module oq_cell (
  input  logic                    clk_i,
  input  oq_pkg::oq_cmd_t         cmd_i,
  input  logic                    occupied_i,
  input  logic                    tail_i,
  input  logic                    hit_i,
  input  logic [oq_pkg::KeyW-1:0] nxt_key_i,
  input  logic [oq_pkg::DurW-1:0] nxt_dur_i,
  output logic                    hit_o,
  output logic                    first_o,
  output logic [oq_pkg::KeyW-1:0] key_o,
  output logic [oq_pkg::DurW-1:0] dur_o
);
  import oq_pkg::*;

  logic [KeyW-1:0] key_q;
  logic [DurW-1:0] dur_q;
  logic            match;

  assign match   = occupied_i && (key_q == cmd_i.key) && (cmd_i.key != '0);
  assign hit_o   = hit_i | match;
  assign first_o = match & ~hit_i;
  assign key_o   = key_q;
  assign dur_o   = dur_q;

  // Entries at or behind the deleted slot take their neighbor's contents.
  always_ff @(posedge clk_i) begin
    if (cmd_i.append && tail_i) begin
      key_q <= cmd_i.key;
      dur_q <= cmd_i.dur;
    end else if (cmd_i.del && hit_o) begin
      key_q <= nxt_key_i;
      dur_q <= nxt_dur_i;
    end
  end

endmodule

[src/ordered_queue_with_key_removal.sv]
// Top level of the ordered queue with search and delete by key.
// An accepted item is staged, then executed, and its result is registered at the output.
// The block takes no new item until the staged one commits; each item takes one pass of
// compare, first-match chain and shift through the cell row. A stalled result holds
// the commit of the next item until the result is taken.
// Reset clears the entry count, the staged item and the handshake state; cells are not reset.
`timescale 1ns / 1ps
module ordered_queue_with_key_removal (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                kind_i,
  input  logic [oq_pkg::KeyW-1:0]   key_i,
  input  logic [oq_pkg::DurW-1:0]   duration_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      ok_o,
  output logic [oq_pkg::KeyW-1:0]   key_out_o,
  output logic [oq_pkg::DurW-1:0]   duration_out_o,
  output logic [oq_pkg::CountW-1:0] count_o
);
  import oq_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e            state_q;
  kind_e             kind_q;
  logic [KeyW-1:0]   key_q;
  logic [DurW-1:0]   dur_q;
  logic [CountW-1:0] count_q, count_d;
  logic              out_valid_q;
  logic              ok_q, ok_d;
  logic [KeyW-1:0]   kout_q, kout_d;
  logic [DurW-1:0]   dout_q, dout_d;
  logic [DurW-1:0]   lookup_dur;

  logic                          accept;
  logic                          commit;
  logic                          append_ok;
  logic                          found;
  oq_cmd_t                       cmd;
  logic [CAPACITY:0]             hit;
  logic [CAPACITY-1:0]           first;
  logic [CAPACITY-1:0]           occupied;
  logic [CAPACITY-1:0]           tail;
  logic [CAPACITY:0][KeyW-1:0]   key_a;
  logic [CAPACITY:0][DurW-1:0]   dur_a;

  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign commit    = (state_q == ST_EXEC) && (!out_valid_q || !out_stall_i);
  assign append_ok = (key_q != '0) && (dur_q != '0) && (count_q < CountW'(CAPACITY));
  assign found     = hit[CAPACITY];

  assign cmd.append = commit && (kind_q == KIND_APPEND) && append_ok;
  assign cmd.del    = commit && ((kind_q == KIND_POP) || (kind_q == KIND_REMOVE));
  assign cmd.key    = key_q;
  assign cmd.dur    = dur_q;

  assign hit[0]          = (kind_q == KIND_POP);
  assign key_a[CAPACITY] = '0;
  assign dur_a[CAPACITY] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occupied[i] = CountW'(i) < count_q;
    assign tail[i]     = CountW'(i) == count_q;

    oq_cell u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .occupied_i (occupied[i]),
      .tail_i     (tail[i]),
      .hit_i      (hit[i]),
      .nxt_key_i  (key_a[i+1]),
      .nxt_dur_i  (dur_a[i+1]),
      .hit_o      (hit[i+1]),
      .first_o    (first[i]),
      .key_o      (key_a[i]),
      .dur_o      (dur_a[i])
    );
  end

  always_comb begin
    lookup_dur = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first[i]) begin
        lookup_dur = lookup_dur | dur_a[i];
      end
    end
  end

  always_comb begin
    ok_d    = 1'b0;
    kout_d  = '0;
    dout_d  = '0;
    count_d = count_q;
    case (kind_q)
      KIND_APPEND: begin
        if (append_ok) begin
          ok_d    = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      KIND_POP: begin
        if (count_q != '0) begin
          ok_d    = 1'b1;
          kout_d  = key_a[0];
          dout_d  = dur_a[0];
          count_d = count_q - 1'b1;
        end
      end
      KIND_LOOKUP: begin
        if (found) begin
          ok_d   = 1'b1;
          dout_d = lookup_dur;
        end
      end
      KIND_REMOVE: begin
        if (found) begin
          ok_d    = 1'b1;
          count_d = count_q - 1'b1;
        end
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kind_q      <= KIND_APPEND;
      key_q       <= '0;
      dur_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      ok_q        <= 1'b0;
      kout_q      <= '0;
      dout_q      <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && !commit) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_EXEC;
            kind_q  <= kind_e'(kind_i);
            key_q   <= key_i;
            dur_q   <= duration_i;
          end
        end
        ST_EXEC: begin
          if (commit) begin
            state_q     <= ST_IDLE;
            count_q     <= count_d;
            out_valid_q <= 1'b1;
            ok_q        <= ok_d;
            kout_q      <= kout_d;
            dout_q      <= dout_d;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign ok_o           = ok_q;
  assign key_out_o      = kout_q;
  assign duration_out_o = dout_q;
  assign count_o        = count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_EXEC)
    else $error("accepted item not executed");

  a_commit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q)
    else $error("result lost after commit");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !commit |=> count_q == $past(count_q))
    else $error("count changed without commit");

  a_single_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(first))
    else $error("more than one first match");

endmodule
